@@ src/thc_pkg.sv @@
// ----------------------------------------------------------------------------
// thc_pkg
// Shared widths, duty codes and register indexes of the thermostat heater
// and fan controller.
// ----------------------------------------------------------------------------
package thc_pkg;

	// Field widths.
	localparam int TEMP_W = 15;
	localparam int BAND_W = 12;
	localparam int CODE_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;

	// Signed width that holds a temperature plus or minus a band.
	localparam int CMP_W = TEMP_W + 2;

	// Heater duty codes.
	localparam logic [CODE_W-1:0] HEAT_FULL = 4'd0;
	localparam logic [CODE_W-1:0] HEAT_HIGH = 4'd2;
	localparam logic [CODE_W-1:0] HEAT_MID  = 4'd5;

	// Fan duty codes.
	localparam logic [CODE_W-1:0] FAN_FULL = 4'd0;
	localparam logic [CODE_W-1:0] FAN_HIGH = 4'd3;
	localparam logic [CODE_W-1:0] FAN_MID  = 4'd6;

	// Shared off code.
	localparam logic [CODE_W-1:0] CODE_OFF = 4'd11;

	// Register reset values.
	localparam logic [TEMP_W-1:0] TARGET_RST = 15'd2400;
	localparam logic [TEMP_W-1:0] SPIKE_RST  = 15'd150;
	localparam logic [BAND_W-1:0] INNER_RST  = 12'd200;
	localparam logic [BAND_W-1:0] OUTER_RST  = 12'd400;
	localparam logic [BAND_W-1:0] REARM_RST  = 12'd150;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 3'd0,
		REG_SPIKE  = 3'd1,
		REG_INNER  = 3'd2,
		REG_OUTER  = 3'd3,
		REG_REARM  = 3'd4
	} cfg_reg_t;

endpackage

@@ src/thermostat_heater_fan_controller_top.sv @@
// ----------------------------------------------------------------------------
// thermostat_heater_fan_controller_top
// Spike filter, heater and fan duty selection with hysteresis.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, reading) carries one temperature
// reading per beat. The output channel (out_valid, out_ready, filtered_temp,
// heater_duty_code, fan_duty_code, heater_on) carries one result per beat.
// Configuration is to be written through cfg_we, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this. A
// write takes effect at once. A reading accepted into the input register
// loads the result register and the filter and hysteresis state once the
// result register is free. Throughput: one reading per cycle while
// out_ready stays high, set by the single state update stage, which reads
// and rewrites the filter and hysteresis registers on every advance.
// Reset clears both stages, loads the register defaults and returns the
// filter and hysteresis state to its power-up values.
// When the receiver stalls, the result register holds its beat; the input
// register fills behind it and in_ready then drops until out_ready returns.
// ----------------------------------------------------------------------------
module thermostat_heater_fan_controller_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port
	input  logic                          cfg_we,
	input  logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thc_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [thc_pkg::TEMP_W-1:0]     reading,
	// Output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [thc_pkg::TEMP_W-1:0]     filtered_temp,
	output logic [thc_pkg::CODE_W-1:0]     heater_duty_code,
	output logic [thc_pkg::CODE_W-1:0]     fan_duty_code,
	output logic                          heater_on
);
	import thc_pkg::*;

	// Configuration registers.
	logic [TEMP_W-1:0] target_q;
	logic [TEMP_W-1:0] spike_q;
	logic [BAND_W-1:0] inner_q;
	logic [BAND_W-1:0] outer_q;
	logic [BAND_W-1:0] rearm_q;

	// Input stage.
	logic              valid_s1;
	logic [TEMP_W-1:0] reading_s1;

	// Filter and hysteresis state.
	logic [TEMP_W-1:0] last_q;
	logic              hold_q;
	logic              latch_q;
	logic              armed_q;
	logic [CODE_W-1:0] heat_code_q;
	logic [CODE_W-1:0] fan_code_q;

	// Result stage.
	logic              valid_s2;
	logic [TEMP_W-1:0] filt_s2;

	// Next-state values.
	logic              advance;
	logic [TEMP_W-1:0] filt_d;
	logic [TEMP_W-1:0] last_d;
	logic              hold_d;
	logic              latch_d;
	logic              armed_d;
	logic [CODE_W-1:0] heat_code_d;
	logic [CODE_W-1:0] fan_code_d;
	logic [TEMP_W:0]   diff;
	logic [TEMP_W-1:0] abs_diff;

	// Signed comparison operands.
	logic signed [CMP_W-1:0] t;
	logic signed [CMP_W-1:0] tg;
	logic signed [CMP_W-1:0] lo_inner;
	logic signed [CMP_W-1:0] hi_inner;
	logic signed [CMP_W-1:0] lo_outer;
	logic signed [CMP_W-1:0] hi_outer;
	logic signed [CMP_W-1:0] lo_rearm;

	// Handshake: the input stage moves on when the result register is free.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			spike_q  <= SPIKE_RST;
			inner_q  <= INNER_RST;
			outer_q  <= OUTER_RST;
			rearm_q  <= REARM_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TARGET: target_q <= cfg_data[TEMP_W-1:0];
				REG_SPIKE:  spike_q  <= cfg_data[TEMP_W-1:0];
				REG_INNER:  inner_q  <= cfg_data[BAND_W-1:0];
				REG_OUTER:  outer_q  <= cfg_data[BAND_W-1:0];
				REG_REARM:  rearm_q  <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			reading_s1 <= reading;
		end
	end

	// Spike filter: a large jump is held once, then the next reading passes.
	always_comb begin
		diff     = {1'b0, reading_s1} - {1'b0, last_q};
		abs_diff = diff[TEMP_W] ? TEMP_W'(-diff) : diff[TEMP_W-1:0];
		filt_d   = reading_s1;
		last_d   = reading_s1;
		hold_d   = 1'b0;
		if (!hold_q && (abs_diff > spike_q)) begin
			hold_d = 1'b1;
			filt_d = last_q;
			last_d = last_q;
		end
	end

	// Band limits around the target.
	always_comb begin
		t        = CMP_W'(signed'({1'b0, filt_d}));
		tg       = CMP_W'(signed'({1'b0, target_q}));
		lo_inner = tg - CMP_W'(signed'({1'b0, inner_q}));
		hi_inner = tg + CMP_W'(signed'({1'b0, inner_q}));
		lo_outer = tg - CMP_W'(signed'({1'b0, outer_q}));
		hi_outer = tg + CMP_W'(signed'({1'b0, outer_q}));
		lo_rearm = tg - CMP_W'(signed'({1'b0, rearm_q}));
	end

	// Heater code; inside the inner band only an active latch writes it.
	always_comb begin
		heat_code_d = heat_code_q;
		priority if (t > lo_inner && t < hi_inner) begin
			if (latch_q) begin
				heat_code_d = HEAT_MID;
			end
		end else if (t > lo_outer && t < lo_inner) begin
			heat_code_d = HEAT_HIGH;
		end else if (t < lo_outer) begin
			heat_code_d = HEAT_FULL;
		end else begin
			heat_code_d = CODE_OFF;
		end
	end

	// Fan code and arming; the mid code fires once per arming.
	always_comb begin
		fan_code_d = fan_code_q;
		armed_d    = armed_q;
		priority if (t > tg && t < hi_inner) begin
			if (!latch_q && armed_q) begin
				fan_code_d = FAN_MID;
				armed_d    = 1'b0;
			end
		end else if (t > hi_inner && t < hi_outer) begin
			fan_code_d = FAN_HIGH;
		end else if (t >= hi_outer) begin
			fan_code_d = FAN_FULL;
		end else begin
			fan_code_d = CODE_OFF;
		end
		if (t < lo_rearm) begin
			armed_d = 1'b1;
		end
	end

	// Heater latch: set below the inner band, cleared above it.
	always_comb begin
		latch_d = latch_q;
		if (!latch_q && t < tg && t < lo_inner) begin
			latch_d = 1'b1;
		end else if (latch_q && t > tg && t > hi_inner) begin
			latch_d = 1'b0;
		end
	end

	// State update, one reading per advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			hold_q      <= 1'b0;
			latch_q     <= 1'b0;
			armed_q     <= 1'b1;
			heat_code_q <= CODE_OFF;
			fan_code_q  <= CODE_OFF;
		end else if (advance) begin
			last_q      <= last_d;
			hold_q      <= hold_d;
			latch_q     <= latch_d;
			armed_q     <= armed_d;
			heat_code_q <= heat_code_d;
			fan_code_q  <= fan_code_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			filt_s2 <= filt_d;
		end
	end

	assign out_valid        = valid_s2;
	assign filtered_temp    = filt_s2;
	assign heater_duty_code = heat_code_q;
	assign fan_duty_code    = fan_code_q;
	assign heater_on        = latch_q;

endmodule

@@ src/thc_checker.sv @@
// ----------------------------------------------------------------------------
// thc_checker
// Port-level checks of the thermostat heater and fan controller.
// ----------------------------------------------------------------------------
module thc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [thc_pkg::TEMP_W-1:0]    filtered_temp,
	input logic [thc_pkg::CODE_W-1:0]    heater_duty_code,
	input logic [thc_pkg::CODE_W-1:0]    fan_duty_code,
	input logic                         heater_on
);
	import thc_pkg::*;

	// A stalled result beat stays and keeps its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered_temp)
			&& $stable(heater_duty_code) && $stable(fan_duty_code) && $stable(heater_on))
		else $error("result beat changed while stalled");

	// Heater code is one of its four levels.
	a_heat_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heater_duty_code == HEAT_FULL || heater_duty_code == HEAT_HIGH
			|| heater_duty_code == HEAT_MID || heater_duty_code == CODE_OFF))
		else $error("illegal heater duty code");

	// Fan code is one of its four levels.
	a_fan_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fan_duty_code == FAN_FULL || fan_duty_code == FAN_HIGH
			|| fan_duty_code == FAN_MID || fan_duty_code == CODE_OFF))
		else $error("illegal fan duty code");

	// The fan mid code is only reached and kept while the heater is off.
	a_fan_mid_heater_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fan_duty_code == FAN_MID |-> !heater_on)
		else $error("fan mid code with heater on");

endmodule

bind thermostat_heater_fan_controller_top thc_checker u_thc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.filtered_temp    (filtered_temp),
	.heater_duty_code (heater_duty_code),
	.fan_duty_code    (fan_duty_code),
	.heater_on        (heater_on)
);
